@@ rtl/core/ulbp_pkg.sv @@
// ----------------------------------------------------------------------------
// ulbp_pkg: uniform lbp code map shared definitions
// register indexes, field widths and the 256-entry uniform code table
// ----------------------------------------------------------------------------
package ulbp_pkg;

   localparam int PIXEL_W = 8;
   localparam int CODE_W  = 6;
   localparam int POS_W   = 10;
   localparam int CSR_W   = 11;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [CODE_W-1:0] code_table_type [256];

   function automatic logic is_uniform(input logic [7:0] p);
      logic [7:0] x;
      int         n;
      x = p ^ {p[6:0], p[7]};
      n = 0;
      for (int i = 0; i < 8; i++) begin
         n = n + int'(x[i]);
      end
      return (n <= 2);
   endfunction

   // rank of each uniform pattern in ascending order, 0 for the rest
   function automatic code_table_type build_code_table();
      code_table_type t;
      int             rank;
      rank = 0;
      for (int p = 0; p < 256; p++) begin
         if (is_uniform(8'(p))) begin
            rank = rank + 1;
            t[p] = CODE_W'(rank);
         end else begin
            t[p] = '0;
         end
      end
      return t;
   endfunction

   localparam code_table_type CODE_TABLE = build_code_table();

endpackage

@@ rtl/core/ulbp_ram.sv @@
// ----------------------------------------------------------------------------
// ulbp_ram: generic single-write, single-read ram
// one write port, one read port with registered, enabled read data
// ----------------------------------------------------------------------------
module ulbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/uniform_lbp_code_map.sv @@
// ----------------------------------------------------------------------------
// uniform_lbp_code_map: 3x3 uniform local binary pattern code map
// streams grayscale pixels in raster order and gives one 59-bin code per
// interior centre pixel
// ----------------------------------------------------------------------------
// One pixel word is taken every clock unless the result side stalls. The code
// for a centre follows the acceptance of its bottom-right neighbour: stage one
// reads both line buffer rams, stage two shifts the 3x3 window, compares and
// looks up the code into the output register. Border pixels give no word. Line
// buffers need no clearing pass, so the block is ready straight after reset.
// image_width and image_height are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT;
// frame_start on a pixel restarts the frame at row 0, column 0.
module uniform_lbp_code_map #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  ulbp_pkg::csr_index_type       csr_addr,
   input  logic [ulbp_pkg::CSR_W-1:0]    csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // pixel
   input  logic                          req_tuser,   // frame_start
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,   // uniform_code, center_row, center_col
   output logic                          rsp_tlast    // frame_last
);

   import ulbp_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [CSR_W-1:0]   width_ff, height_ff;
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CW-1:0]      wm1, c0;
   logic [RW-1:0]      hm1, r0;
   logic               accept, adv;

   logic               s1_valid_ff;
   logic [PIXEL_W-1:0] s1_px_ff;
   logic [CW-1:0]      s1_col_ff;
   logic               s1_interior_ff, s1_last_ff;
   logic [POS_W-1:0]   s1_row_out_ff, s1_col_out_ff;
   logic               hit_ff;
   logic [PIXEL_W-1:0] fwd_ff;

   logic [PIXEL_W-1:0] upper_rd, middle_rd, up, mid;
   logic [PIXEL_W-1:0] win_ff [3][3];
   logic [PIXEL_W-1:0] win_in [3][3];
   logic [7:0]         pattern;

   logic               rsp_valid_ff;
   logic [CODE_W-1:0]  code_ff;
   logic [POS_W-1:0]   row_out_ff, col_out_ff;
   logic               last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_W'(32);
         height_ff <= CSR_W'(32);
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // last column and row indexes after clamping
   always_comb begin
      if (width_ff < CSR_W'(3)) begin
         wm1 = CW'(2);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         wm1 = CW'(MAX_WIDTH - 1);
      end else begin
         wm1 = CW'(width_ff - CSR_W'(1));
      end
      if (height_ff < CSR_W'(3)) begin
         hm1 = RW'(2);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         hm1 = RW'(MAX_HEIGHT - 1);
      end else begin
         hm1 = RW'(height_ff - CSR_W'(1));
      end
   end

   assign adv        = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || adv;
   assign accept     = req_tvalid && req_tready;

   assign c0 = req_tuser ? '0 : col_ff;
   assign r0 = req_tuser ? '0 : row_ff;

   always_comb begin
      if (c0 >= wm1) begin
         col_in = '0;
         row_in = (r0 >= hm1) ? '0 : r0 + RW'(1);
      end else begin
         col_in = c0 + CW'(1);
         row_in = r0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line buffers
   ulbp_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (adv),
      .wr_addr (s1_col_ff),
      .wr_data (mid),
      .rd_en   (accept),
      .rd_addr (c0),
      .rd_data (upper_rd)
   );

   ulbp_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (c0),
      .wr_data (req_tdata),
      .rd_en   (accept),
      .rd_addr (c0),
      .rd_data (middle_rd)
   );

   // stage one: read data in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
         hit_ff      <= adv && (s1_col_ff == c0);
      end else if (adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff       <= req_tdata;
         s1_col_ff      <= c0;
         s1_interior_ff <= (r0 >= RW'(2)) && (c0 >= CW'(2));
         s1_last_ff     <= (r0 == hm1) && (c0 == wm1);
         s1_row_out_ff  <= POS_W'(r0 - RW'(1));
         s1_col_out_ff  <= POS_W'(c0 - CW'(1));
         fwd_ff         <= mid;
      end
   end

   // upper write of the item ahead lands after this read on a repeated column
   assign up  = hit_ff ? fwd_ff : upper_rd;
   assign mid = middle_rd;

   // stage two: window shift, compare and code lookup
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k][0] = win_ff[k][1];
         win_in[k][1] = win_ff[k][2];
      end
      win_in[0][2] = up;
      win_in[1][2] = mid;
      win_in[2][2] = s1_px_ff;
      pattern = {win_in[0][0] >= win_in[1][1],
                 win_in[0][1] >= win_in[1][1],
                 win_in[0][2] >= win_in[1][1],
                 win_in[1][2] >= win_in[1][1],
                 win_in[2][2] >= win_in[1][1],
                 win_in[2][1] >= win_in[1][1],
                 win_in[2][0] >= win_in[1][1],
                 win_in[1][0] >= win_in[1][1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (adv) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s1_interior_ff;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         code_ff    <= CODE_TABLE[pattern];
         row_out_ff <= s1_row_out_ff;
         col_out_ff <= s1_col_out_ff;
         last_ff    <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, col_out_ff, row_out_ff, code_ff};
   assign rsp_tlast  = last_ff;

endmodule

@@ sim/uniform_lbp_code_map_test.sv @@
// ----------------------------------------------------------------------------
// uniform_lbp_code_map_test: self-checking bench for the uniform lbp code map
// Pixel words are streamed with random gaps and random result back-pressure.
// A behavioural copy of the line buffers, 3x3 window and position counters
// predicts each code word, which is matched field by field in arrival order.
// Runs a partial frame at reset sizes, a hand-checked 3x3 table, then random
// frames with clamped sizes, broken and noisy sequences.
// ----------------------------------------------------------------------------
module uniform_lbp_code_map_test;

   localparam int MAX_DIM      = 1024;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 900;
   localparam int N_DIRECTED   = 29;

   typedef struct packed {
      logic [5:0] code;
      logic [9:0] crow;
      logic [9:0] ccol;
      logic       last;
   } lbp_word_type;

   typedef struct packed {
      logic [7:0]   pixel;
      logic         frame_start;
      logic         has_word;
      lbp_word_type word;
   } directed_row_type;

   localparam lbp_word_type NO_WORD = '0;

   // 3x3 frames: one centre each, code arrives with the ninth pixel
   localparam directed_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      // flat frame, every neighbour equal to the centre
      '{8'd170, 1'b1, 1'b0, NO_WORD},
      '{8'd170, 1'b0, 1'b0, NO_WORD},
      '{8'd170, 1'b0, 1'b0, NO_WORD},
      '{8'd170, 1'b0, 1'b0, NO_WORD},
      '{8'd170, 1'b0, 1'b0, NO_WORD},
      '{8'd170, 1'b0, 1'b0, NO_WORD},
      '{8'd170, 1'b0, 1'b0, NO_WORD},
      '{8'd170, 1'b0, 1'b0, NO_WORD},
      '{8'd170, 1'b0, 1'b1, '{6'd58, 10'd1, 10'd1, 1'b1}},
      // frame abandoned after two pixels
      '{8'd85,  1'b1, 1'b0, NO_WORD},
      '{8'd85,  1'b0, 1'b0, NO_WORD},
      // bright centre on black, restarts mid-frame
      '{8'd0,   1'b1, 1'b0, NO_WORD},
      '{8'd0,   1'b0, 1'b0, NO_WORD},
      '{8'd0,   1'b0, 1'b0, NO_WORD},
      '{8'd0,   1'b0, 1'b0, NO_WORD},
      '{8'd255, 1'b0, 1'b0, NO_WORD},
      '{8'd0,   1'b0, 1'b0, NO_WORD},
      '{8'd0,   1'b0, 1'b0, NO_WORD},
      '{8'd0,   1'b0, 1'b0, NO_WORD},
      '{8'd0,   1'b0, 1'b1, '{6'd1, 10'd1, 10'd1, 1'b1}},
      // alternating ring, non-uniform, frame follows the wrap with no start flag
      '{8'd200, 1'b0, 1'b0, NO_WORD},
      '{8'd50,  1'b0, 1'b0, NO_WORD},
      '{8'd200, 1'b0, 1'b0, NO_WORD},
      '{8'd50,  1'b0, 1'b0, NO_WORD},
      '{8'd128, 1'b0, 1'b0, NO_WORD},
      '{8'd50,  1'b0, 1'b0, NO_WORD},
      '{8'd200, 1'b0, 1'b0, NO_WORD},
      '{8'd50,  1'b0, 1'b0, NO_WORD},
      '{8'd200, 1'b0, 1'b1, '{6'd0, 10'd1, 10'd1, 1'b1}}
   };

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   ulbp_pkg::csr_index_type         csr_addr;
   logic [ulbp_pkg::CSR_W-1:0]      csr_wdata;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [7:0]                      req_tdata;   // pixel
   logic                            req_tuser;   // frame_start
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [31:0]                     rsp_tdata;   // uniform_code, center_row, center_col
   logic                            rsp_tlast;   // frame_last

   // predicted block state
   logic [10:0]  width_reg;
   logic [10:0]  height_reg;
   bit   [7:0]   upper_row_mem  [MAX_DIM];
   bit   [7:0]   middle_row_mem [MAX_DIM];
   bit   [7:0]   win [3][3];
   int unsigned  row_pos;
   int unsigned  col_pos;
   logic [5:0]   code_of_pattern [256];

   lbp_word_type pending_codes [$];
   int           mismatch_count;
   bit           req_no_gap;
   bit           rsp_no_stall;

   uniform_lbp_code_map i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("status: fail");
      $finish;
   end

   function automatic int unsigned clamp_dim(input logic [10:0] v);
      if (v < 11'd3) return 3;
      if (v > 11'(MAX_DIM)) return MAX_DIM;
      return int'(v);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch: %s", msg);
   endtask

   // one pixel through line buffers, window and counters
   task automatic compute_code_for_pixel(input logic [7:0] px, input logic fs,
                                         output bit has, output lbp_word_type res);
      int unsigned w, h, r, c;
      bit [7:0]    up, mid, ctr, pat;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      if (fs) begin
         row_pos = 0;
         col_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      if (c >= MAX_DIM) c = MAX_DIM - 1;
      up = upper_row_mem[c];
      mid = middle_row_mem[c];
      upper_row_mem[c] = mid;
      middle_row_mem[c] = px;
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = px;
      has = 1'b0;
      res = '0;
      if (r >= 2 && c >= 2) begin
         ctr = win[1][1];
         pat = {win[0][0] >= ctr, win[0][1] >= ctr, win[0][2] >= ctr, win[1][2] >= ctr,
                win[2][2] >= ctr, win[2][1] >= ctr, win[2][0] >= ctr, win[1][0] >= ctr};
         res.code = code_of_pattern[pat];
         res.crow = 10'(r - 1);
         res.ccol = 10'(c - 1);
         res.last = (r == h - 1) && (c == w - 1);
         has = 1'b1;
      end
      if (c >= w - 1) begin
         col_pos = 0;
         row_pos = (r >= h - 1) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   // entered and left just after a falling edge
   task automatic send_pixel(input logic [7:0] px, input logic fs, input bit typed,
                             input bit typed_has, input lbp_word_type typed_word);
      int           gap;
      bit           has;
      lbp_word_type res;
      gap = req_no_gap ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      req_tuser <= fs;
      do @(posedge clock); while (!req_tready);
      compute_code_for_pixel(px, fs, has, res);
      if (typed) begin
         has = typed_has;
         res = typed_word;
      end
      if (has) pending_codes.push_back(res);
      @(negedge clock);
   endtask

   task automatic send_frame(input int n, input int style, input bit fs_first,
                             input bit noise);
      int         base, step;
      logic [7:0] px;
      logic       fs;
      base = $urandom_range(0, 253);
      step = $urandom_range(1, 7);
      for (int i = 0; i < n; i++) begin
         case (style)
            0: px = 8'($urandom_range(0, 255));
            1: px = 8'(base + $urandom_range(0, 2));
            default: px = 8'(i * step + $urandom_range(0, 1));
         endcase
         fs = (i == 0) ? fs_first : (noise && $urandom_range(0, 3) == 0);
         send_pixel(px, fs, 1'b0, 1'b0, NO_WORD);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_codes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input ulbp_pkg::csr_index_type idx,
                                 input logic [10:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      if (idx == ulbp_pkg::REG_IMAGE_WIDTH) width_reg = val;
      else height_reg = val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // result side: random stall per word, then check against oldest prediction
   initial begin
      int           stall;
      lbp_word_type got, want;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = rsp_no_stall ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.code = rsp_tdata[5:0];
         got.crow = rsp_tdata[15:6];
         got.ccol = rsp_tdata[25:16];
         got.last = rsp_tlast;
         if (pending_codes.size() == 0) begin
            report_mismatch($sformatf("unexpected word code %0d at (%0d,%0d)",
                                      got.code, got.crow, got.ccol));
         end else begin
            want = pending_codes.pop_front();
            if (got.code !== want.code)
               report_mismatch($sformatf("code %0d, want %0d at (%0d,%0d)",
                                         got.code, want.code, want.crow, want.ccol));
            if (got.crow !== want.crow)
               report_mismatch($sformatf("centre row %0d, want %0d", got.crow, want.crow));
            if (got.ccol !== want.ccol)
               report_mismatch($sformatf("centre col %0d, want %0d", got.ccol, want.ccol));
            if (got.last !== want.last)
               report_mismatch($sformatf("frame last %0b, want %0b at (%0d,%0d)",
                                         got.last, want.last, want.crow, want.ccol));
         end
         @(negedge clock);
      end
   end

   initial begin
      int          rank, n, kind, random_items;
      int unsigned frame_len;
      bit          cut_short;
      logic [7:0]  pv;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_addr = ulbp_pkg::REG_IMAGE_WIDTH;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_no_gap = 1'b0;
      rsp_no_stall = 1'b0;
      mismatch_count = 0;
      width_reg = 11'd32;
      height_reg = 11'd32;
      row_pos = 0;
      col_pos = 0;
      rank = 0;
      for (int p = 0; p < 256; p++) begin
         pv = 8'(p);
         if ($countones(pv ^ {pv[0], pv[7:1]}) <= 2) begin
            rank++;
            code_of_pattern[p] = 6'(rank);
         end else begin
            code_of_pattern[p] = '0;
         end
      end
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // reset sizes, five rows of the 32 wide default frame
      send_frame(160, 0, 1'b1, 1'b0);
      wait_drained();

      write_register(ulbp_pkg::REG_IMAGE_WIDTH, 11'd3);
      write_register(ulbp_pkg::REG_IMAGE_HEIGHT, 11'd3);
      for (int i = 0; i < N_DIRECTED; i++)
         send_pixel(DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].frame_start, 1'b1,
                    DIRECTED_ROWS[i].has_word, DIRECTED_ROWS[i].word);
      wait_drained();

      // random frames, some cut short, some with stray frame starts
      random_items = 0;
      cut_short = 1'b1;
      while (random_items < RANDOM_ITEMS) begin
         if (cut_short || $urandom_range(0, 2) == 0) begin
            wait_drained();
            if ($urandom_range(0, 1) == 0)
               write_register(ulbp_pkg::REG_IMAGE_WIDTH, ($urandom_range(0, 9) == 0) ?
                              11'($urandom_range(0, 2)) : 11'($urandom_range(3, 10)));
            if ($urandom_range(0, 1) == 0)
               write_register(ulbp_pkg::REG_IMAGE_HEIGHT, ($urandom_range(0, 9) == 0) ?
                              11'($urandom_range(0, 2)) : 11'($urandom_range(3, 8)));
         end
         req_no_gap = ($urandom_range(0, 3) == 0);
         rsp_no_stall = ($urandom_range(0, 3) == 0);
         frame_len = clamp_dim(width_reg) * clamp_dim(height_reg);
         kind = $urandom_range(0, 9);
         n = (kind < 7) ? int'(frame_len) : $urandom_range(1, frame_len);
         send_frame(n, $urandom_range(0, 2),
                    cut_short ? $urandom_range(0, 1) == 0 : $urandom_range(0, 3) != 0,
                    kind == 9);
         cut_short = (kind >= 7);
         random_items += n;
      end
      req_no_gap = 1'b0;
      wait_drained();

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/ulbp_pkg.sv
rtl/core/ulbp_ram.sv
rtl/core/uniform_lbp_code_map.sv
sim/uniform_lbp_code_map_test.sv
